[rtl/tlvd_pkg.sv]
// tlvd_pkg: shared types, codes and constants of the tlv message deframer
// no dependencies; imported by every module of the block
`default_nettype none

package tlvd_pkg;

    // datagram limits
    localparam int MAX_DATAGRAM_BYTES = 4096;
    localparam int HEADER_BYTES       = 4;
    localparam int LEN_W              = 16;
    localparam logic [LEN_W-1:0] BODY_BYTE_LIMIT = LEN_W'(MAX_DATAGRAM_BYTES - HEADER_BYTES);

    // stream widths
    localparam int S_TDATA_W = 8;

    // configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  MAGIC_RESET   = 8'd93;
    localparam logic [CFG_DATA_W-1:0]  VERSION_RESET = 8'd2;

    // header byte positions
    localparam int HDR_IDX_W = 3;
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC   = 3'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_VERSION = 3'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI  = 3'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO  = 3'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_DONE    = 3'd4;

    // tlv types with fixed body sizes
    localparam logic [2:0] TLV_PAD       = 3'd0;
    localparam logic [2:0] TLV_HELLO     = 3'd2;
    localparam logic [2:0] TLV_NEIGHBOUR = 3'd3;
    localparam logic [2:0] TLV_ACK       = 3'd5;
    localparam logic [7:0] TLV_MAX_TYPE  = 8'd7;

    localparam logic [7:0] HELLO_SHORT_BYTES = 8'd8;
    localparam logic [7:0] HELLO_LONG_BYTES  = 8'd16;
    localparam logic [7:0] NEIGHBOUR_BYTES   = 8'd18;
    localparam logic [7:0] ACK_BYTES         = 8'd12;

    typedef enum logic [1:0] {
        ROLE_HEADER = 2'd0,
        ROLE_TYPE   = 2'd1,
        ROLE_LENGTH = 2'd2,
        ROLE_BODY   = 2'd3
    } byte_role_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_MAGIC        = 3'd2,
        ST_VERSION      = 3'd3,
        ST_LENGTH       = 3'd4,
        ST_UNKNOWN_TYPE = 3'd5,
        ST_TRUNCATED    = 3'd6
    } msg_status_t;

    // how the back end treats a queued byte
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_WALK   = 2'd1,
        KIND_DROP   = 2'd2
    } item_kind_t;

    // queue entry from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        item_kind_t  kind;
        msg_status_t pre_status;
    } tlvd_item_t;

    // result beat, role in the lowest bits
    typedef struct packed {
        msg_status_t status;
        logic [7:0]  offset;
        logic [7:0]  length;
        logic [2:0]  tlv_type;
        byte_role_t  role;
    } tlvd_result_t;

    localparam int M_TDATA_W = $bits(tlvd_result_t);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [7:0] body_size(input logic [2:0] tlv_type, input logic [7:0] len);
        logic [7:0] sz;
        case (tlv_type)
            TLV_HELLO:     sz = (len == HELLO_SHORT_BYTES) ? HELLO_SHORT_BYTES : HELLO_LONG_BYTES;
            TLV_NEIGHBOUR: sz = NEIGHBOUR_BYTES;
            TLV_ACK:       sz = ACK_BYTES;
            default:       sz = len;
        endcase
        return sz;
    endfunction

endpackage

`default_nettype wire

[rtl/tlvd_front.sv]
// tlvd_front: accepts datagram bytes, checks the header and counts body bytes
// depends on tlvd_pkg; feeds tlvd_fifo
`default_nettype none

module tlvd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tlvd_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [tlvd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlvd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                q_full,
    output logic                                q_push,
    output tlvd_pkg::tlvd_item_t                q_item
);
    import tlvd_pkg::*;

    logic [CFG_DATA_W-1:0] magic_reg, version_reg;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [LEN_W-1:0]      decl_len_reg, decl_len_next;
    logic [LEN_W-1:0]      count_reg, count_next;
    msg_status_t           herr_reg, herr_next;
    item_kind_t            kind;
    msg_status_t           pre_status;
    logic                  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    always_comb begin
        hdr_idx_next  = hdr_idx_reg;
        decl_len_next = decl_len_reg;
        count_next    = count_reg;
        herr_next     = herr_reg;
        kind          = KIND_HEADER;
        if (hdr_idx_reg != HDR_DONE) begin
            case (hdr_idx_reg)
                HDR_MAGIC: begin
                    if (s_tdata != magic_reg && herr_reg == ST_OK) herr_next = ST_MAGIC;
                end
                HDR_VERSION: begin
                    if (s_tdata != version_reg && herr_reg == ST_OK) herr_next = ST_VERSION;
                end
                HDR_LEN_HI: decl_len_next = {s_tdata, 8'd0};
                HDR_LEN_LO: decl_len_next = {decl_len_reg[15:8], s_tdata};
                default: ;
            endcase
            hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
        end else if (count_reg >= BODY_BYTE_LIMIT) begin
            // oversize tail is passed on but not walked
            kind = KIND_DROP;
        end else begin
            kind       = KIND_WALK;
            count_next = count_reg + LEN_W'(1);
        end

        // header side of the final status, back end adds tlv errors
        pre_status = ST_OK;
        if (s_tlast) begin
            if (hdr_idx_next != HDR_DONE)       pre_status = ST_SHORT;
            else if (herr_next != ST_OK)        pre_status = herr_next;
            else if (count_next != decl_len_next) pre_status = ST_LENGTH;
        end
    end

    always_comb begin
        q_item.data       = s_tdata;
        q_item.last       = s_tlast;
        q_item.kind       = kind;
        q_item.pre_status = pre_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= MAGIC_RESET;
            version_reg  <= VERSION_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MAGIC:   magic_reg   <= cfg_wr_data;
                CFG_VERSION: version_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_idx_reg  <= HDR_MAGIC;
            decl_len_reg <= '0;
            count_reg    <= '0;
            herr_reg     <= ST_OK;
        end else if (accept) begin
            if (s_tlast) begin
                hdr_idx_reg  <= HDR_MAGIC;
                decl_len_reg <= '0;
                count_reg    <= '0;
                herr_reg     <= ST_OK;
            end else begin
                hdr_idx_reg  <= hdr_idx_next;
                decl_len_reg <= decl_len_next;
                count_reg    <= count_next;
                herr_reg     <= herr_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tlvd_fifo.sv]
// tlvd_fifo: short queue of classified bytes between front and back end
// depends on tlvd_pkg
`default_nettype none

module tlvd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tlvd_pkg::tlvd_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output tlvd_pkg::tlvd_item_t head_item,
    output logic                 empty
);
    import tlvd_pkg::*;

    tlvd_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QUEUE_CNT_W'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/tlvd_back.sv]
// tlvd_back: walks the tlvs of queued body bytes and drives the result beat
// depends on tlvd_pkg; takes entries from tlvd_fifo
`default_nettype none

module tlvd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  tlvd_pkg::tlvd_item_t            q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlvd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import tlvd_pkg::*;

    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } walk_phase_t;

    walk_phase_t  phase_reg, phase_next;
    logic [2:0]   cur_type_reg, cur_type_next;
    logic [7:0]   cur_len_reg, cur_len_next;
    logic [7:0]   remaining_reg, remaining_next;
    logic [7:0]   offset_reg, offset_next;
    logic         type_err_reg, type_err_next;
    logic [7:0]   sz;
    tlvd_result_t res, res_reg;
    logic         m_tvalid_reg;
    logic         m_tlast_reg;

    assign q_pop    = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;
    assign m_tlast  = m_tlast_reg;
    assign sz       = body_size(cur_type_reg, q_head.data);

    always_comb begin
        phase_next     = phase_reg;
        cur_type_next  = cur_type_reg;
        cur_len_next   = cur_len_reg;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        type_err_next  = type_err_reg;
        res.role       = ROLE_HEADER;
        res.tlv_type   = '0;
        res.length     = '0;
        res.offset     = '0;
        res.status     = ST_OK;

        case (q_head.kind)
            KIND_HEADER: ;
            KIND_DROP:   res.role = ROLE_BODY;
            KIND_WALK: begin
                case (phase_reg)
                    PH_TYPE: begin
                        res.role = ROLE_TYPE;
                        if (q_head.data > TLV_MAX_TYPE) begin
                            type_err_next = 1'b1;
                            phase_next    = PH_STOP;
                            cur_type_next = TLV_PAD;
                            cur_len_next  = '0;
                        end else if (q_head.data[2:0] == TLV_PAD) begin
                            // pad is a single byte, no length follows
                            cur_type_next = TLV_PAD;
                            cur_len_next  = '0;
                        end else begin
                            res.tlv_type  = q_head.data[2:0];
                            cur_type_next = q_head.data[2:0];
                            cur_len_next  = '0;
                            phase_next    = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        res.role     = ROLE_LENGTH;
                        res.tlv_type = cur_type_reg;
                        res.length   = q_head.data;
                        cur_len_next = q_head.data;
                        offset_next  = '0;
                        if (sz == '0) begin
                            phase_next = PH_TYPE;
                        end else begin
                            remaining_next = sz;
                            phase_next     = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        res.role       = ROLE_BODY;
                        res.tlv_type   = cur_type_reg;
                        res.length     = cur_len_reg;
                        res.offset     = offset_reg;
                        offset_next    = offset_reg + 8'd1;
                        remaining_next = remaining_reg - 8'd1;
                        if (remaining_reg == 8'd1) phase_next = PH_TYPE;
                    end
                    PH_STOP: res.role = ROLE_BODY;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (q_head.last) begin
            if (q_head.pre_status != ST_OK)                  res.status = q_head.pre_status;
            else if (type_err_next)                          res.status = ST_UNKNOWN_TYPE;
            else if (phase_next == PH_LEN || phase_next == PH_BODY) res.status = ST_TRUNCATED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            cur_type_reg  <= '0;
            cur_len_reg   <= '0;
            remaining_reg <= '0;
            offset_reg    <= '0;
            type_err_reg  <= 1'b0;
        end else if (q_pop) begin
            if (q_head.last) begin
                phase_reg     <= PH_TYPE;
                cur_type_reg  <= '0;
                cur_len_reg   <= '0;
                remaining_reg <= '0;
                offset_reg    <= '0;
                type_err_reg  <= 1'b0;
            end else begin
                phase_reg     <= phase_next;
                cur_type_reg  <= cur_type_next;
                cur_len_reg   <= cur_len_next;
                remaining_reg <= remaining_next;
                offset_reg    <= offset_next;
                type_err_reg  <= type_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (q_pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg     <= res;
            m_tlast_reg <= q_head.last;
        end
    end

`ifndef ASSERT_OFF
    a_status_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tlast_reg |-> res_reg.status == ST_OK)
        else $error("status reported on a beat that does not end the datagram");

    a_header_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.role == ROLE_HEADER
            |-> res_reg.tlv_type == '0 && res_reg.length == '0 && res_reg.offset == '0)
        else $error("header beat carries tlv fields");

    a_rearm_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_head.last |=> phase_reg == PH_TYPE && !type_err_reg)
        else $error("walk state not cleared after end of datagram");

    a_body_has_bytes_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> remaining_reg != '0)
        else $error("in tlv body with no bytes remaining");
`endif

endmodule

`default_nettype wire

[rtl/tlv_message_deframer.sv]
// tlv_message_deframer: top level, header check and tlv walk of datagram bytes
// depends on tlvd_pkg, tlvd_front, tlvd_fifo, tlvd_back
//
//   channel   dir  width  contents
//   s_axis    in   8+1    tdata = data_byte, tlast = last_byte
//   m_axis    out  24+1   tdata = role, type, length, offset, status; tlast = msg_done
//   cfg       in   1+8    register 0 magic, register 1 version
//
// with m_tready high: one byte per clock sustained, the tlv walk one byte a cycle
// an accepted byte goes into the queue and is registered onto m_axis when the output is free
// a four-entry queue lets the input keep flowing while the output stalls, until full
// synchronous active-low reset clears all message state, magic and version reload
`default_nettype none

module tlv_message_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tlvd_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [tlvd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlvd_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] byte_role, [4:2] tlv_type, [12:5] tlv_length, [20:13] body_offset,
    // [23:21] msg_status
    output logic [tlvd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import tlvd_pkg::*;

    tlvd_item_t push_item, head_item;
    logic       q_push, q_pop, q_full, q_empty;

    tlvd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    tlvd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    tlvd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[tb/sv/tb_tlv_message_deframer.sv]
// tb_tlv_message_deframer: self-checking bench for the tlv message deframer
// builds good and broken datagrams, predicts every result beat and compares them
// depends on tlvd_pkg and tlv_message_deframer
module tb_tlv_message_deframer;
    import tlvd_pkg::*;

    localparam int CYCLE_LIMIT      = 1500000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int MAX_REPORTS      = 10;
    localparam int BYTES_PER_PHASE  = 100;
    localparam int NUM_PHASES       = 5;

    typedef enum logic [1:0] {
        WALK_TYPE,
        WALK_LEN,
        WALK_BODY,
        WALK_STOP
    } walk_phase_t;

    typedef enum int {
        MSG_GOOD,
        MSG_BAD_MAGIC,
        MSG_BAD_VERSION,
        MSG_BAD_LENGTH,
        MSG_UNKNOWN_TYPE,
        MSG_TRUNCATED,
        MSG_SHORT,
        MSG_NOISE,
        MSG_OVERSIZE
    } msg_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic         done;
        tlvd_result_t fields;
    } out_beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    tlv_message_deframer u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // deframer state as the bench sees it
    logic [7:0]       magic_reg;
    logic [7:0]       version_reg;
    logic [2:0]       hdr_idx;
    logic [15:0]      decl_len;
    logic [15:0]      body_cnt;
    walk_phase_t      walk;
    logic [2:0]       cur_type;
    logic [7:0]       cur_len;
    logic [7:0]       remaining;
    logic [7:0]       offset;
    msg_status_t      held_err;

    in_beat_t         pending[$];
    out_beat_t        expected_beats[$];
    logic [7:0]       frame[$];
    logic [7:0]       body[$];

    int               queued = 0;
    int               mismatches = 0;
    int               results_seen = 0;
    int               cycle_count = 0;
    int               send_gap = 0;
    int               stall_left = 0;
    bit               long_hold_done = 1'b0;
    bit               calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] tlv_body_bytes(input logic [2:0] t, input logic [7:0] len);
        logic [7:0] sz;
        sz = len;
        if (t == TLV_NEIGHBOUR)
            sz = NEIGHBOUR_BYTES;
        else if (t == TLV_ACK)
            sz = ACK_BYTES;
        else if (t == TLV_HELLO)
            sz = (len == HELLO_SHORT_BYTES) ? HELLO_SHORT_BYTES : HELLO_LONG_BYTES;
        return sz;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_msg();
        hdr_idx   = HDR_MAGIC;
        decl_len  = '0;
        body_cnt  = '0;
        walk      = WALK_TYPE;
        cur_type  = TLV_PAD;
        cur_len   = '0;
        remaining = '0;
        offset    = '0;
        held_err  = ST_OK;
    endtask

    task automatic latch_error(input msg_status_t code);
        if (held_err == ST_OK)
            held_err = code;
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic last_in);
        out_beat_t  e;
        logic [7:0] sz;
        e = '0;
        e.done = last_in;
        e.fields.role = ROLE_HEADER;
        e.fields.status = ST_OK;
        if (hdr_idx < HDR_DONE) begin
            case (hdr_idx)
                HDR_MAGIC: begin
                    if (b != magic_reg)
                        latch_error(ST_MAGIC);
                end
                HDR_VERSION: begin
                    if (b != version_reg)
                        latch_error(ST_VERSION);
                end
                HDR_LEN_HI: decl_len = {b, 8'h00};
                default:    decl_len[7:0] = b;
            endcase
            hdr_idx = hdr_idx + 3'd1;
        end else if (body_cnt >= BODY_BYTE_LIMIT) begin
            // past the size limit: dropped, not walked
            e.fields.role = ROLE_BODY;
        end else begin
            body_cnt = body_cnt + 16'd1;
            case (walk)
                WALK_TYPE: begin
                    e.fields.role = ROLE_TYPE;
                    cur_len = '0;
                    if (b > TLV_MAX_TYPE) begin
                        latch_error(ST_UNKNOWN_TYPE);
                        walk = WALK_STOP;
                        cur_type = TLV_PAD;
                    end else if (b[2:0] == TLV_PAD) begin
                        cur_type = TLV_PAD;
                    end else begin
                        e.fields.tlv_type = b[2:0];
                        cur_type = b[2:0];
                        walk = WALK_LEN;
                    end
                end
                WALK_LEN: begin
                    e.fields.role = ROLE_LENGTH;
                    e.fields.tlv_type = cur_type;
                    e.fields.length = b;
                    cur_len = b;
                    sz = tlv_body_bytes(cur_type, b);
                    offset = '0;
                    if (sz == 0) begin
                        walk = WALK_TYPE;
                    end else begin
                        remaining = sz;
                        walk = WALK_BODY;
                    end
                end
                WALK_BODY: begin
                    e.fields.role = ROLE_BODY;
                    e.fields.tlv_type = cur_type;
                    e.fields.length = cur_len;
                    e.fields.offset = offset;
                    offset = offset + 8'd1;
                    remaining = remaining - 8'd1;
                    if (remaining == 0)
                        walk = WALK_TYPE;
                end
                default: e.fields.role = ROLE_BODY;
            endcase
        end
        if (last_in) begin
            if (hdr_idx < HDR_DONE)
                e.fields.status = ST_SHORT;
            else if (held_err == ST_MAGIC || held_err == ST_VERSION)
                e.fields.status = held_err;
            else if (body_cnt != decl_len)
                e.fields.status = ST_LENGTH;
            else if (held_err != ST_OK)
                e.fields.status = held_err;
            else if (walk == WALK_LEN || walk == WALK_BODY)
                e.fields.status = ST_TRUNCATED;
            else
                e.fields.status = ST_OK;
            clear_msg();
        end
        expected_beats.push_back(e);
    endtask

    task automatic put_header(input logic [7:0] m, input logic [7:0] v, input logic [15:0] len16);
        frame.push_back(m);
        frame.push_back(v);
        frame.push_back(len16[15:8]);
        frame.push_back(len16[7:0]);
    endtask

    task automatic send_frame();
        in_beat_t ib;
        foreach (frame[i]) begin
            ib.data = frame[i];
            ib.last = (i == frame.size() - 1);
            pending.push_back(ib);
        end
        queued += frame.size();
        frame.delete();
    endtask

    task automatic add_tlv();
        logic [7:0] t;
        logic [7:0] len;
        logic [7:0] sz;
        t = 8'($urandom_range(0, 7));
        body.push_back(t);
        if (t[2:0] == TLV_PAD)
            return;
        if (t[2:0] == TLV_HELLO && $urandom_range(0, 1) != 0)
            len = HELLO_SHORT_BYTES;
        else if ($urandom_range(0, 9) != 0)
            len = 8'($urandom_range(0, 20));
        else
            len = 8'($urandom);
        body.push_back(len);
        sz = tlv_body_bytes(t[2:0], len);
        repeat (sz) body.push_back(8'($urandom));
    endtask

    task automatic build_message(input msg_kind_t kind);
        int          n;
        logic [15:0] declared;
        logic [7:0]  t;
        logic [7:0]  len;
        logic [7:0]  sz;
        logic [7:0]  m;
        logic [7:0]  v;
        body.delete();
        if (kind == MSG_SHORT || kind == MSG_NOISE) begin
            n = (kind == MSG_SHORT) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            frame.push_back(($urandom_range(0, 1) != 0) ? magic_reg : 8'($urandom));
            repeat (n - 1) frame.push_back(8'($urandom));
            send_frame();
            return;
        end
        if (kind == MSG_OVERSIZE) begin
            while (body.size() < BODY_BYTE_LIMIT + 24)
                add_tlv();
        end else begin
            repeat ($urandom_range(0, 4)) add_tlv();
        end
        if (kind == MSG_UNKNOWN_TYPE) begin
            body.push_back(8'($urandom_range(8, 255)));
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
        end
        if (kind == MSG_TRUNCATED) begin
            // stop after the type byte or somewhere inside the body
            t = 8'($urandom_range(1, 7));
            body.push_back(t);
            if ($urandom_range(0, 2) != 0) begin
                len = 8'($urandom_range(1, 30));
                body.push_back(len);
                sz = tlv_body_bytes(t[2:0], len);
                repeat ($urandom_range(0, sz - 1)) body.push_back(8'($urandom));
            end
        end
        declared = (kind == MSG_OVERSIZE) ? BODY_BYTE_LIMIT : 16'(body.size());
        if (kind == MSG_BAD_LENGTH) begin
            if ($urandom_range(0, 1) != 0) begin
                declared = (declared != 0 && $urandom_range(0, 1) != 0) ? declared - 16'd1
                                                                        : declared + 16'd1;
            end else begin
                do declared = 16'($urandom); while (declared == body.size());
            end
        end
        m = (kind == MSG_BAD_MAGIC) ? magic_reg ^ 8'($urandom_range(1, 255)) : magic_reg;
        v = (kind == MSG_BAD_VERSION) ? version_reg ^ 8'($urandom_range(1, 255)) : version_reg;
        put_header(m, v, declared);
        foreach (body[i]) frame.push_back(body[i]);
        send_frame();
    endtask

    task automatic drain();
        do @(negedge aclk); while (pending.size() != 0 || s_tvalid || expected_beats.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        if (idx == CFG_MAGIC)
            magic_reg = val;
        else
            version_reg = val;
    endtask

    // input side: one beat in flight, refilled from the pending queue
    always @(posedge aclk) begin : drive_bytes
        in_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
            magic_reg = MAGIC_RESET;
            version_reg = VERSION_RESET;
            clear_msg();
        end else begin
            if (s_tvalid && s_tready)
                classify_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.last;
                    send_gap <= draw_gap();
                end
            end
        end
    end

    // result side back-pressure, with one long hold to fill the block
    always @(posedge aclk) begin : pace_results
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            m_tready <= 1'b0;
            stall_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            stall_left <= draw_gap();
        end
    end

    always @(posedge aclk) begin : check_results
        tlvd_result_t got;
        out_beat_t    want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tlvd_result_t'(m_tdata);
            results_seen <= results_seen + 1;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                want = expected_beats.pop_front();
                if (got.role !== want.fields.role || got.tlv_type !== want.fields.tlv_type ||
                    got.length !== want.fields.length || got.offset !== want.fields.offset ||
                    got.status !== want.fields.status || m_tlast !== want.done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"beat %0d: expected role %0d type %0d len %0d off %0d ",
                                  "done %b status %0d, got role %0d type %0d len %0d off %0d ",
                                  "done %b status %0d"}, results_seen,
                                 want.fields.role, want.fields.tlv_type, want.fields.length,
                                 want.fields.offset, want.done, want.fields.status,
                                 got.role, got.tlv_type, got.length, got.offset,
                                 m_tlast, got.status);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        // switch between idling and no-idling stretches
        if (cycle_count % 64 == 0)
            calm <= ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** tlv_message_deframer: FAILED **");
            $finish;
        end
    end

    initial begin : run_test
        int          p;
        int          start;
        int          r;
        logic [7:0]  mg;
        logic [7:0]  vr;
        msg_kind_t   kind;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-built datagrams under the reset register values
        frame.push_back(magic_reg);
        send_frame();
        put_header(magic_reg, version_reg, 16'h0000);
        send_frame();
        // magic error outranks the length mismatch
        put_header(~magic_reg, version_reg, 16'hffff);
        send_frame();
        put_header(magic_reg, ~version_reg, 16'h0000);
        send_frame();
        // unknown type stops the walk, next byte is not walked
        put_header(magic_reg, version_reg, 16'h0002);
        frame.push_back(8'hff);
        frame.push_back(8'h00);
        send_frame();
        // datagram ends right after a type byte
        put_header(magic_reg, version_reg, 16'h0001);
        frame.push_back(TLV_MAX_TYPE);
        send_frame();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain();
                case (p)
                    1: begin
                        mg = 8'h00;
                        vr = 8'h00;
                    end
                    2: begin
                        mg = 8'hff;
                        vr = 8'hff;
                    end
                    3: begin
                        mg = 8'($urandom);
                        vr = 8'($urandom);
                    end
                    default: begin
                        mg = MAGIC_RESET;
                        vr = VERSION_RESET;
                    end
                endcase
                write_reg(CFG_MAGIC, mg);
                write_reg(CFG_VERSION, vr);
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
            end
            start = queued;
            while (queued - start < BYTES_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 50)      kind = MSG_GOOD;
                else if (r < 57) kind = MSG_BAD_MAGIC;
                else if (r < 64) kind = MSG_BAD_VERSION;
                else if (r < 71) kind = MSG_BAD_LENGTH;
                else if (r < 80) kind = MSG_UNKNOWN_TYPE;
                else if (r < 89) kind = MSG_TRUNCATED;
                else if (r < 94) kind = MSG_SHORT;
                else             kind = MSG_NOISE;
                build_message(kind);
            end
            if (p == NUM_PHASES - 1)
                build_message(MSG_OVERSIZE);
        end

        drain();
        if (mismatches == 0)
            $display("** tlv_message_deframer: PASSED **");
        else
            $display("** tlv_message_deframer: FAILED **");
        $finish;
    end

endmodule
